// ----- hdl/mqufi_pkg.sv -----
// Shared constants, codes and types for the urgent front-insert multi-queue.
package mqufi_pkg;

   // Field widths of the item and result channels.
   localparam int MODE_W  = 1;
   localparam int QIDX_W  = 5;
   localparam int ID_W    = 16;
   localparam int LIMIT_W = 4;
   localparam int OCC_W   = 4;

   // Queue geometry.
   localparam int NUM_QUEUES  = 32;
   localparam int QUEUE_DEPTH = 8;

   // Derived widths: ring pointer, fill count, pointer sum, queue select, slot address.
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Queue limit after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_ADD  = 1'b0;
   localparam logic [MODE_W-1:0] MODE_TAKE = 1'b1;

   // Result outcome codes.
   typedef enum logic [1:0] {
      OUTCOME_ADDED  = 2'd0,
      OUTCOME_FULL   = 2'd1,
      OUTCOME_SERVED = 2'd2,
      OUTCOME_EMPTY  = 2'd3
   } outcome_type;

endpackage

// ----- hdl/mqufi_if.sv -----
// Handshake channel interfaces for items, results and the limit register.

// Item channel: add or take on one class queue.
interface mqufi_req_if import mqufi_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [QIDX_W-1:0] queue_index;
   logic [ID_W-1:0]   entry_id;
   logic              urgent;

   modport source (output valid, output mode, output queue_index, output entry_id,
                   output urgent, input ready);
   modport sink   (input valid, input mode, input queue_index, input entry_id,
                   input urgent, output ready);
endinterface

// Result channel: one result item per accepted item.
interface mqufi_rsp_if import mqufi_pkg::*;;
   logic             valid;
   logic             ready;
   logic [1:0]       outcome;
   logic [ID_W-1:0]  served_id;
   logic             served_urgent;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, output outcome, output served_id, output served_urgent,
                   output occupancy, input ready);
   modport sink   (input valid, input outcome, input served_id, input served_urgent,
                   input occupancy, output ready);
endinterface

// Configuration write channel for the queue limit.
interface mqufi_csr_if import mqufi_pkg::*;;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] queue_limit;

   modport source (output valid, output queue_limit, input ready);
   modport sink   (input valid, input queue_limit, output ready);
endinterface

// ----- hdl/multi_queue_urgent_front_insert_unit.sv -----
// Top level of the bounded multi-queue with urgent front insert.

// Keeps 32 class queues of up to 8 entries each. An add appends a regular entry
// at the back or puts an urgent entry at the front, and is rejected once the
// queue holds the configured limit (saturated at the depth). A take removes the
// front entry. Every item gives one result: the input stage reads and updates
// the queue's head pointer and count and issues the slot memory access, and the
// memory stage passes the slot read data into the result register. The
// two stages and the result register form a pipeline, so one item is taken per
// cycle as long as results are taken; the single port of the slot memory sets
// that rate. The head pointers and counts clear at reset; slot contents need no
// clearing, so items are accepted right after reset.
module multi_queue_urgent_front_insert_unit import mqufi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mqufi_req_if.sink   req_if,
   mqufi_rsp_if.source rsp_if,
   mqufi_csr_if.sink   csr_if
);

   // Configuration register.
   logic [LIMIT_W-1:0] limit_ff;

   // Per-queue ring state.
   logic [PTR_W-1:0] head_ff [NUM_QUEUES];
   logic [CNT_W-1:0] cnt_ff  [NUM_QUEUES];

   // Slot memory: urgent flag above the identifier.
   logic [ID_W:0] slot_mem [SLOTS];
   logic [ID_W:0] rd_ff;

   // Input stage.
   logic              p1_valid_ff;
   logic              p1_valid_in;
   logic [MODE_W-1:0] p1_mode_ff;
   logic [QIDX_W-1:0] p1_q_ff;
   logic [ID_W-1:0]   p1_id_ff;
   logic              p1_urgent_ff;

   // Memory stage.
   logic              p2_valid_ff;
   logic              p2_valid_in;
   outcome_type       p2_outcome_ff;
   logic [OCC_W-1:0]  p2_occ_ff;
   logic              p2_serve_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   outcome_type       rsp_outcome_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_urgent_ff;
   logic [OCC_W-1:0]  rsp_occ_ff;

   // Handshake and advance signals.
   logic req_accept;
   logic p1_adv;
   logic p2_adv;

   // Queue update logic.
   logic [QSEL_W-1:0] q_sel;
   logic              in_range;
   logic [PTR_W-1:0]  cur_head;
   logic [CNT_W-1:0]  cur_cnt;
   logic [CNT_W-1:0]  lim;
   logic [PTR_W-1:0]  head_dec;
   logic [PTR_W-1:0]  head_inc;
   logic [SUM_W-1:0]  back_sum;
   logic [PTR_W-1:0]  back_pos;
   logic [PTR_W-1:0]  pos;
   logic [PTR_W-1:0]  new_head;
   logic [CNT_W-1:0]  new_cnt;
   logic              upd_en;
   logic              wr_en;
   logic              serve;
   outcome_type       outcome;
   logic [OCC_W-1:0]  occ;
   logic [ADDR_W-1:0] slot_addr;

   // Pipeline flow: a stage moves on when the stage after it is empty or moving.
   assign p2_adv       = p2_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign p1_adv       = p1_valid_ff && (!p2_valid_ff || p2_adv);
   assign req_if.ready = !p1_valid_ff || p1_adv;
   assign req_accept   = req_if.valid && req_if.ready;
   assign p1_valid_in  = req_accept || (p1_valid_ff && !p1_adv);
   assign p2_valid_in  = p1_adv || (p2_valid_ff && !p2_adv);
   assign rsp_valid_in = p2_adv || (rsp_valid_ff && !rsp_if.ready);

   // Configuration register write; the port never stalls.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_if.valid) begin
         limit_ff <= csr_if.queue_limit;
      end
   end

   // Look up the addressed queue and work out the ring positions.
   assign q_sel    = QSEL_W'(p1_q_ff);
   assign in_range = int'(p1_q_ff) < NUM_QUEUES;
   assign cur_head = head_ff[q_sel];
   assign cur_cnt  = cnt_ff[q_sel];
   assign lim      = (int'(limit_ff) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(limit_ff);
   assign head_dec = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
   assign head_inc = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   assign back_sum = {1'b0, cur_head} + SUM_W'(cur_cnt);
   assign back_pos = (int'(back_sum) >= QUEUE_DEPTH) ?
                     PTR_W'(back_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(back_sum);

   // Decide the outcome and the new head and count of the addressed queue.
   always_comb begin
      outcome  = OUTCOME_EMPTY;
      new_head = cur_head;
      new_cnt  = cur_cnt;
      pos      = cur_head;
      upd_en   = 1'b0;
      wr_en    = 1'b0;
      serve    = 1'b0;
      if (!in_range) begin
         outcome = (p1_mode_ff == MODE_ADD) ? OUTCOME_FULL : OUTCOME_EMPTY;
      end else if (p1_mode_ff == MODE_ADD) begin
         upd_en = 1'b1;
         if (cur_cnt >= lim) begin
            outcome = OUTCOME_FULL;
         end else begin
            if (p1_urgent_ff) begin
               new_head = head_dec;
               pos      = head_dec;
            end else begin
               pos = back_pos;
            end
            wr_en   = 1'b1;
            new_cnt = cur_cnt + 1'b1;
            outcome = OUTCOME_ADDED;
         end
      end else begin
         upd_en = 1'b1;
         if (cur_cnt == '0) begin
            outcome = OUTCOME_EMPTY;
         end else begin
            serve    = 1'b1;
            new_head = head_inc;
            new_cnt  = cur_cnt - 1'b1;
            outcome  = OUTCOME_SERVED;
         end
      end
   end

   assign occ       = in_range ? OCC_W'(new_cnt) : '0;
   assign slot_addr = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);

   // Per-queue head pointers and counts, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (p1_adv && upd_en) begin
         head_ff[q_sel] <= new_head;
         cnt_ff[q_sel]  <= new_cnt;
      end
   end

   // Slot memory: one registered read per advancing item, plus a write for an accepted add.
   always_ff @(posedge clock) begin
      if (p1_adv && wr_en) begin
         slot_mem[slot_addr] <= {p1_urgent_ff, p1_id_ff};
      end
      if (p1_adv) begin
         rd_ff <= slot_mem[slot_addr];
      end
   end

   // Stage valid bits and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_mode_ff   <= req_if.mode;
         p1_q_ff      <= req_if.queue_index;
         p1_id_ff     <= req_if.entry_id;
         p1_urgent_ff <= req_if.urgent;
      end
   end

   // Memory stage payload.
   always_ff @(posedge clock) begin
      if (p1_adv) begin
         p2_outcome_ff <= outcome;
         p2_occ_ff     <= occ;
         p2_serve_ff   <= serve;
      end
   end

   // Result register; identifier and flag read as zero unless an entry was served.
   always_ff @(posedge clock) begin
      if (p2_adv) begin
         rsp_outcome_ff <= p2_outcome_ff;
         rsp_occ_ff     <= p2_occ_ff;
         rsp_id_ff      <= p2_serve_ff ? rd_ff[ID_W-1:0] : '0;
         rsp_urgent_ff  <= p2_serve_ff ? rd_ff[ID_W] : 1'b0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.outcome       = rsp_outcome_ff;
   assign rsp_if.served_id     = rsp_id_ff;
   assign rsp_if.served_urgent = rsp_urgent_ff;
   assign rsp_if.occupancy     = rsp_occ_ff;

`ifndef SYNTHESIS
   // A queue never holds more entries than its ring has slots.
   assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (cur_cnt <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count above depth");

   // An accepted add raises the addressed queue's count by one.
   assert property (@(posedge clock) disable iff (reset)
      (p1_adv && wr_en) |=> (cnt_ff[$past(q_sel)] == $past(cur_cnt) + 1'b1))
      else $error("add did not raise the queue count");

   // A result that serves nothing carries a zero identifier and flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_outcome_ff != OUTCOME_SERVED)) |->
      ((rsp_id_ff == '0) && !rsp_urgent_ff))
      else $error("unserved result carries entry data");

   // The memory stage only fills from an advancing input stage.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(p2_valid_ff)) |-> $past(p1_adv))
      else $error("memory stage filled without an item");
`endif

endmodule
